### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, quiet while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, with the clock and reset names of this project.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/dewd_pkg.sv
package dewd_pkg;

  localparam int unsigned BASE_HEADER_WORDS = 4;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned HLEN_W  = 5;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned INDEX_W = 15;
  localparam int unsigned VALUE_W = 49;
  localparam int unsigned CNT_W   = 3;   // up to seven results per word
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // header lengths that carry sums
  localparam logic [HLEN_W-1:0] HLEN_ESUM = 5'd8;
  localparam logic [HLEN_W-1:0] HLEN_QSUM = 5'd12;
  localparam logic [HLEN_W-1:0] HLEN_BOTH = 5'd16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARDS_PER_CRATE   = 2'd0,
    CFG_CHANNELS_PER_BOARD = 2'd1,
    CFG_FIRST_BOARD_SLOT   = 2'd2
  } cfg_idx_e;

  // result tags
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAN       = 4'd0,
    KIND_SLOT       = 4'd1,
    KIND_CRATE      = 4'd2,
    KIND_ID         = 4'd3,
    KIND_HDRLEN     = 4'd4,
    KIND_EVTLEN     = 4'd5,
    KIND_FINISH     = 4'd6,
    KIND_TIME       = 4'd7,
    KIND_CFD        = 4'd8,
    KIND_CFDFORCED  = 4'd9,
    KIND_ENERGY     = 4'd10,
    KIND_TRACELEN   = 4'd11,
    KIND_OUTOFRANGE = 4'd12,
    KIND_SAMPLE     = 4'd13,
    KIND_ESUM       = 4'd14,
    KIND_QSUM       = 4'd15
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic             accept;  // latch the incoming word
    logic             load;    // load result k into the output register
    logic             last;    // result k is the final one of the word
    logic [CNT_W-1:0] k;
  } dewd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] cnt;     // number of results of the held word
  } dewd_status_t;

endpackage

### rtl/core/digitizer_event_word_decoder.sv
// List-mode event word decoder: takes one 32-bit word per input item and
// emits one tagged result per decoded field (kind, index, value), in the
// order header, time, energy, sums, trace samples. last_of_run marks the
// final result of a word and end_of_event marks every result of the last
// word of an event; words that decode to nothing (the low timestamp word and
// unused header words) produce no result. Throughput is set by the single
// output register, which takes one result per cycle while the output side
// does not stall. A header word yields 7 results, the time and energy words
// 3 each, a trace word 2, a sum word 1 and a silent word none. The next word
// is taken in the same cycle the last result of the current one is loaded.
// The detector id uses one registered multiply (crate by boards per crate)
// followed by a combinational multiply by channels per board, and is ready
// well before its slot in the header run. Configuration writes are always
// accepted and must only be issued while no word is in flight; writes to an
// index beyond the register list are ignored.
`include "assert_macros.svh"

module digitizer_event_word_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // word input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dewd_pkg::WORD_W-1:0]         data_word_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dewd_pkg::KIND_W-1:0]         field_kind_o,
  output logic [dewd_pkg::INDEX_W-1:0]        field_index_o,
  output logic signed [dewd_pkg::VALUE_W-1:0] field_value_o,
  output logic                                last_of_run_o,
  output logic                                end_of_event_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dewd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dewd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dewd_pkg::*;

  dewd_cmd_t    cmd;
  dewd_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer: accept, result stepping, output register valid
  dewd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // word decode, event position tracking, result payload
  dewd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_word_i    (data_word_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .field_kind_o   (field_kind_o),
    .field_index_o  (field_index_o),
    .field_value_o  (field_value_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_event_o (end_of_event_o)
  );

  // a word is never taken while an earlier word still has results to load
  `ASSERT_STD(a_no_accept_midrun, cmd.accept |-> !(cmd.load && !cmd.last),
    "new word taken before the current word's results were loaded")

endmodule

### rtl/core/dewd_ctrl.sv
`include "assert_macros.svh"

module dewd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  dewd_pkg::dewd_status_t status_i,
  output dewd_pkg::dewd_cmd_t    cmd_o
);
  import dewd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             out_valid_q, out_valid_d;

  logic slot_free, is_last, done_now, ready, accept, load;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign is_last   = ({1'b0, k_q} + 4'd1) == {1'b0, status_i.cnt};
  assign load      = (state_q == ST_RUN) && (status_i.cnt != '0) && slot_free;
  // the word is finished once nothing is left or its last result goes out now
  assign done_now  = (state_q == ST_RUN) &&
                     ((status_i.cnt == '0) || (slot_free && is_last));
  assign ready     = (state_q == ST_IDLE) || done_now;
  assign accept    = in_valid_i && ready;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (accept) begin
          k_d = '0;
        end else if (done_now) begin
          state_d = ST_IDLE;
        end else if (load) begin
          k_d = k_q + 3'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !ready;
  assign out_valid_o = out_valid_q;

  assign cmd_o.accept = accept;
  assign cmd_o.load   = load;
  assign cmd_o.last   = is_last;
  assign cmd_o.k      = k_q;

  `ASSERT_STD(a_k_in_range,
    (state_q == ST_RUN && status_i.cnt != '0) |-> (k_q < status_i.cnt),
    "result counter ran past the word's result count")
  `ASSERT_STD(a_out_rise_from_load, $rose(out_valid_q) |-> $past(load),
    "output became valid without a load")
  `ASSERT_STD(a_idle_no_output_pending, (state_q == ST_IDLE && $past(state_q == ST_IDLE))
    |-> !$rose(out_valid_q), "output loaded while idle")

endmodule

### rtl/core/dewd_datapath.sv
`include "assert_macros.svh"

module dewd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dewd_pkg::dewd_cmd_t                cmd_i,
  output dewd_pkg::dewd_status_t             status_o,
  input  logic [dewd_pkg::WORD_W-1:0]        data_word_i,
  input  logic                               cfg_we_i,
  input  logic [dewd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dewd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [dewd_pkg::KIND_W-1:0]        field_kind_o,
  output logic [dewd_pkg::INDEX_W-1:0]       field_index_o,
  output logic signed [dewd_pkg::VALUE_W-1:0] field_value_o,
  output logic                               last_of_run_o,
  output logic                               end_of_event_o
);
  import dewd_pkg::*;

  typedef enum logic [2:0] {
    JOB_NONE  = 3'd0,
    JOB_HDR   = 3'd1,
    JOB_TIME  = 3'd2,
    JOB_ENER  = 3'd3,
    JOB_ESUM  = 3'd4,
    JOB_QSUM  = 3'd5,
    JOB_TRACE = 3'd6
  } job_e;

  // configuration
  logic [4:0] bpc_q, cpb_q;
  logic [3:0] fbs_q;

  // event position state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [HLEN_W-1:0] hdr_q;
  logic [POS_W-1:0]  evt_q;
  logic [WORD_W-1:0] tsl_q;

  // held word and its job
  logic [WORD_W-1:0]  word_q;
  job_e               job_q, job_d;
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic               eoe_q, eoe_d;

  logic [8:0] prod_q;

  // output register
  logic [KIND_W-1:0]         kind_q, kind_d;
  logic [INDEX_W-1:0]        oidx_q, oidx_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic                      lor_q, eoe_out_q;

  logic [POS_W-1:0]  hdr_ext, el_in;
  logic [POS_W:0]    pos_inc;
  logic signed [10:0] id_base;
  logic signed [16:0] id_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_q <= 5'd16;
      cpb_q <= 5'd16;
      fbs_q <= 4'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BOARDS_PER_CRATE:   bpc_q <= cfg_data_i;
        CFG_CHANNELS_PER_BOARD: cpb_q <= cfg_data_i;
        CFG_FIRST_BOARD_SLOT:   fbs_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign hdr_ext = {{(POS_W-HLEN_W){1'b0}}, hdr_q};
  assign pos_inc = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
  assign el_in   = data_word_i[30:17];

  // classify the incoming word against the current position
  always_comb begin
    job_d = JOB_NONE;
    idx_d = '0;
    priority if (pos_q == '0) begin
      job_d = JOB_HDR;
    end else if (pos_q == 14'd1) begin
      job_d = JOB_NONE;
    end else if (pos_q == 14'd2) begin
      job_d = JOB_TIME;
    end else if (pos_q == 14'd3) begin
      job_d = JOB_ENER;
    end else if (pos_q < hdr_ext) begin
      if (hdr_q == HLEN_ESUM || hdr_q == HLEN_BOTH) begin
        if (pos_q < 14'd8) begin
          job_d = JOB_ESUM;
          idx_d = {1'b0, pos_q - 14'(BASE_HEADER_WORDS)};
        end else if (hdr_q == HLEN_BOTH) begin
          job_d = JOB_QSUM;
          idx_d = {1'b0, pos_q - 14'd8};
        end
      end else if (hdr_q == HLEN_QSUM) begin
        job_d = JOB_QSUM;
        idx_d = {1'b0, pos_q - 14'(BASE_HEADER_WORDS)};
      end
    end else begin
      job_d = JOB_TRACE;
      idx_d = {pos_q - hdr_ext, 1'b0};
    end
  end

  // a header never ends its event: the end test skips the word at position zero
  assign eoe_d = (pos_q != '0) && (pos_inc >= {1'b0, evt_q});
  assign pos_d = eoe_d ? '0 : pos_inc[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
      evt_q <= '0;
      tsl_q <= '0;
      job_q <= JOB_NONE;
      eoe_q <= 1'b0;
    end else if (cmd_i.accept) begin
      pos_q <= pos_d;
      job_q <= job_d;
      eoe_q <= eoe_d;
      if (pos_q == '0) begin
        hdr_q <= data_word_i[16:12];
        evt_q <= (el_in < 14'(BASE_HEADER_WORDS)) ? 14'(BASE_HEADER_WORDS) : el_in;
      end
      if (pos_q == 14'd1) begin
        tsl_q <= data_word_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= data_word_i;
      idx_q  <= idx_d;
    end
    prod_q <= {5'b0, word_q[11:8]} * {4'b0, bpc_q};
  end

  always_comb begin
    unique case (job_q)
      JOB_HDR:                    status_o.cnt = 3'd7;
      JOB_TIME, JOB_ENER:         status_o.cnt = 3'd3;
      JOB_ESUM, JOB_QSUM:         status_o.cnt = 3'd1;
      JOB_TRACE:                  status_o.cnt = 3'd2;
      default:                    status_o.cnt = 3'd0;
    endcase
  end

  // id = (crate*boards + slot - first_slot) * channels + channel
  assign id_base = $signed({2'b0, prod_q}) + $signed({7'b0, word_q[7:4]})
                 - $signed({7'b0, fbs_q});
  assign id_val  = 17'(id_base * $signed({1'b0, cpb_q})) + $signed({13'b0, word_q[3:0]});

  always_comb begin
    kind_d = KIND_CHAN;
    oidx_d = '0;
    val_d  = '0;
    unique case (job_q)
      JOB_HDR: begin
        unique case (cmd_i.k)
          3'd0: begin kind_d = KIND_CHAN;   val_d = VALUE_W'(word_q[3:0]);   end
          3'd1: begin kind_d = KIND_SLOT;   val_d = VALUE_W'(word_q[7:4]);   end
          3'd2: begin kind_d = KIND_CRATE;  val_d = VALUE_W'(word_q[11:8]);  end
          3'd3: begin kind_d = KIND_ID;     val_d = VALUE_W'(id_val);        end
          3'd4: begin kind_d = KIND_HDRLEN; val_d = VALUE_W'(word_q[16:12]); end
          3'd5: begin kind_d = KIND_EVTLEN; val_d = VALUE_W'(word_q[30:17]); end
          default: begin kind_d = KIND_FINISH; val_d = VALUE_W'(word_q[31]); end
        endcase
      end
      JOB_TIME: begin
        unique case (cmd_i.k)
          3'd0: begin kind_d = KIND_TIME; val_d = {1'b0, word_q[15:0], tsl_q}; end
          3'd1: begin kind_d = KIND_CFD;  val_d = VALUE_W'(word_q[30:16]);     end
          default: begin kind_d = KIND_CFDFORCED; val_d = VALUE_W'(word_q[31]); end
        endcase
      end
      JOB_ENER: begin
        unique case (cmd_i.k)
          3'd0: begin kind_d = KIND_ENERGY;   val_d = VALUE_W'(word_q[15:0]);  end
          3'd1: begin kind_d = KIND_TRACELEN; val_d = VALUE_W'(word_q[30:16]); end
          default: begin kind_d = KIND_OUTOFRANGE; val_d = VALUE_W'(word_q[31]); end
        endcase
      end
      JOB_ESUM: begin
        kind_d = KIND_ESUM; oidx_d = idx_q; val_d = VALUE_W'(word_q);
      end
      JOB_QSUM: begin
        kind_d = KIND_QSUM; oidx_d = idx_q; val_d = VALUE_W'(word_q);
      end
      JOB_TRACE: begin
        kind_d = KIND_SAMPLE;
        if (cmd_i.k == '0) begin
          oidx_d = idx_q;
          val_d  = VALUE_W'(word_q[13:0]);
        end else begin
          oidx_d = idx_q + 15'd1;
          val_d  = VALUE_W'(word_q[29:16]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_d;
      oidx_q    <= oidx_d;
      val_q     <= val_d;
      lor_q     <= cmd_i.last;
      eoe_out_q <= eoe_q;
    end
  end

  assign field_kind_o   = kind_q;
  assign field_index_o  = oidx_q;
  assign field_value_o  = val_q;
  assign last_of_run_o  = lor_q;
  assign end_of_event_o = eoe_out_q;

  `ASSERT_STD(a_pos_in_span, (pos_q != '0) |-> (pos_q < evt_q),
    "word position beyond event span")

endmodule
